@@ hdl/dkrs_pkg.sv @@
package dkrs_pkg;

  localparam int NUM_BUTTONS_DEF = 6;
  localparam int COUNT_BITS_DEF  = 8;
  localparam int THR_BITS        = 8;
  localparam int CODE_BITS       = 7;
  localparam int NUM_KEY_REGS    = 6;
  localparam int APB_ADDR_BITS   = 5;
  localparam int APB_DATA_BITS   = 32;
  localparam int REG_IDX_BITS    = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_KEY_FIRST = 3'd1;

  localparam logic [1:0] PH_WAIT    = 2'd0;
  localparam logic [1:0] PH_RELEASE = 2'd1;
  localparam logic [1:0] PH_SEND    = 2'd2;

  typedef logic [CODE_BITS-1:0] code_t;
  typedef code_t [NUM_KEY_REGS-1:0] keys_t;

  localparam logic [THR_BITS-1:0] THR_RESET = 8'd200;
  localparam keys_t KEY_RESET = {7'd8, 7'd26, 7'd9, 7'd7, 7'd22, 7'd4};

  typedef struct packed {
    logic  valid;
    code_t key_code;
    logic  is_release;
  } result_t;

endpackage

@@ hdl/dkrs_lane.sv @@
module dkrs_lane import dkrs_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                level_i,
  input  logic [THR_BITS-1:0] threshold_i,
  input  logic                grant_i,
  output logic                cand_o
);

  localparam int CMP_BITS = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;

  logic [COUNT_BITS-1:0] press_q, press_d, press_inc;
  logic [COUNT_BITS-1:0] rel_q, rel_d, rel_inc;
  logic                  armed_q, armed_d;
  logic [CMP_BITS-1:0]   thr_ext;
  logic                  press_hit, rel_hit;

  assign press_inc = press_q + 1'b1;
  assign rel_inc   = rel_q + 1'b1;
  assign thr_ext   = CMP_BITS'(threshold_i);
  assign press_hit = CMP_BITS'(press_inc) >= thr_ext;
  assign rel_hit   = CMP_BITS'(rel_inc) >= thr_ext;
  assign cand_o    = level_i & armed_q & press_hit;

  always_comb begin
    press_d = press_q;
    rel_d   = rel_q;
    armed_d = armed_q;
    if (en_i) begin
      if (level_i) begin
        if (grant_i) begin
          press_d = '0;
          armed_d = 1'b0;
        end else begin
          press_d = press_inc;
        end
      end else begin
        if (rel_hit && !armed_q) begin
          rel_d   = '0;
          armed_d = 1'b1;
        end else begin
          rel_d = rel_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q <= '0;
      rel_q   <= '0;
      armed_q <= 1'b0;
    end else begin
      press_q <= press_d;
      rel_q   <= rel_d;
      armed_q <= armed_d;
    end
  end

endmodule

@@ hdl/dkrs_seq.sv @@
module dkrs_seq import dkrs_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [NUM_BUTTONS-1:0] cand_i,
  input  logic                   link_ready_i,
  input  logic                   host_seen_i,
  input  keys_t                  keys_i,
  output logic [NUM_BUTTONS-1:0] grant_o,
  output result_t                res_o
);

  localparam int IDX_BITS = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  logic [1:0]          phase_q, phase_d, phase_mid;
  logic [IDX_BITS-1:0] pend_q, pend_d, pend_mid, sel_idx;
  logic [NUM_BUTTONS-1:0] grant;
  code_t               sel_code;

  assign grant   = (phase_q == PH_WAIT) ? (cand_i & (~cand_i + 1'b1)) : '0;
  assign grant_o = grant;

  always_comb begin
    sel_idx = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (grant[i]) begin
        sel_idx = sel_idx | IDX_BITS'(i);
      end
    end
  end

  assign phase_mid = (|grant) ? PH_SEND : phase_q;
  assign pend_mid  = (|grant) ? sel_idx : pend_q;

  always_comb begin
    sel_code = '0;
    for (int k = 0; k < NUM_KEY_REGS; k++) begin
      if (int'(pend_mid) == k) begin
        sel_code = keys_i[k];
      end
    end
  end

  always_comb begin
    phase_d         = phase_mid;
    pend_d          = pend_mid;
    res_o.valid      = 1'b0;
    res_o.key_code   = '0;
    res_o.is_release = 1'b0;
    if (link_ready_i && host_seen_i) begin
      case (phase_mid)
        PH_SEND: begin
          phase_d        = PH_RELEASE;
          res_o.valid    = en_i;
          res_o.key_code = sel_code;
        end
        PH_RELEASE: begin
          phase_d          = PH_WAIT;
          res_o.valid      = en_i;
          res_o.is_release = 1'b1;
        end
        default: begin
          phase_d = PH_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      pend_q  <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
    end
  end

`ifndef SYNTHESIS
  a_grant_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(grant))
    else $error("more than one button selected in a tick");

  a_grant_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (grant != '0) |-> (phase_q == PH_WAIT))
    else $error("button selected while a report is outstanding");

  a_send_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && link_ready_i && host_seen_i && phase_q == PH_SEND)
      |=> (phase_q == PH_RELEASE))
    else $error("key report not followed by a release phase");
`endif

endmodule

@@ hdl/dkrs_outbuf.sv @@
module dkrs_outbuf import dkrs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  result_t res_i,
  output logic    space_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output code_t   key_code_o,
  output logic    is_release_o
);

  code_t      code_q [2];
  logic       rel_q  [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push        = res_i.valid;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != 2'd0;
  assign space_o     = cnt_q != 2'd2;
  assign key_code_o  = code_q[rd_ptr_q];
  assign is_release_o = rel_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      code_q[wr_ptr_q] <= res_i.key_code;
      rel_q[wr_ptr_q]  <= res_i.is_release;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !push)
    else $error("result pushed into a full output queue");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i)
      |=> (out_valid_o && $stable(key_code_o) && $stable(is_release_o)))
    else $error("waiting report changed before it was taken");
`endif

endmodule

@@ hdl/debounced_key_report_sequencer.sv @@
// Debounced key report sequencer. Each accepted request is one poll tick.
// Every button lane updates its press or release counter in parallel; the
// lowest-numbered lane that qualifies is chosen in the same cycle, and its
// key report is queued in that cycle if link_ready_i and host_seen_i are
// high, its release report on a later such tick. Reports leave through a
// two-entry output queue: in_ready_o drops only while both entries wait to
// be taken, so the tick rate is one per cycle whenever results are drained.
module debounced_key_report_sequencer import dkrs_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [NUM_BUTTONS-1:0]   buttons_pressed_i,
  input  logic                     link_ready_i,
  input  logic                     host_seen_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output code_t                    key_code_o,
  output logic                     is_release_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  logic [THR_BITS-1:0]     thr_q, thr_d;
  keys_t                   keys_q, keys_d;
  logic [REG_IDX_BITS-1:0] reg_idx;
  logic                    wr_en, accept, space;
  logic [NUM_BUTTONS-1:0]  cand, grant;
  result_t                 res;

  assign pready     = 1'b1;
  assign reg_idx    = paddr[APB_ADDR_BITS-1:2];
  assign wr_en      = psel && penable && pwrite;
  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  always_comb begin
    thr_d  = thr_q;
    keys_d = keys_q;
    if (wr_en) begin
      if (reg_idx == REG_THRESHOLD) begin
        thr_d = pwdata[THR_BITS-1:0];
      end
      for (int k = 0; k < NUM_KEY_REGS; k++) begin
        if (reg_idx == REG_KEY_FIRST + REG_IDX_BITS'(k)) begin
          keys_d[k] = pwdata[CODE_BITS-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_THRESHOLD) begin
      prdata = APB_DATA_BITS'(thr_q);
    end
    for (int k = 0; k < NUM_KEY_REGS; k++) begin
      if (reg_idx == REG_KEY_FIRST + REG_IDX_BITS'(k)) begin
        prdata = APB_DATA_BITS'(keys_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RESET;
      keys_q <= KEY_RESET;
    end else begin
      thr_q  <= thr_d;
      keys_q <= keys_d;
    end
  end

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    dkrs_lane #(
      .COUNT_BITS(COUNT_BITS)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (accept),
      .level_i    (buttons_pressed_i[i]),
      .threshold_i(thr_q),
      .grant_i    (grant[i]),
      .cand_o     (cand[i])
    );
  end

  dkrs_seq #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (accept),
    .cand_i      (cand),
    .link_ready_i(link_ready_i),
    .host_seen_i (host_seen_i),
    .keys_i      (keys_q),
    .grant_o     (grant),
    .res_o       (res)
  );

  dkrs_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .key_code_o  (key_code_o),
    .is_release_o(is_release_o)
  );

endmodule
